>>> rtl/core/euc_multibyte_decoder_defines.svh
// Assertion macros for the EUC multibyte decoder.
// Used by the top level; expects clk and arst_n in the enclosing scope.
`ifndef EUC_MULTIBYTE_DECODER_DEFINES_SVH
`define EUC_MULTIBYTE_DECODER_DEFINES_SVH

// The condition must imply the consequence in the same cycle.
`define EUCMBD_ASSERT_IMP(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// The condition must imply the consequence in the next cycle.
`define EUCMBD_ASSERT_NXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/eucmbd_pkg.sv
// Shared types, constants and helper functions of the EUC multibyte decoder.
// No dependencies; imported by the cfg, input stage, core and top files and the testbench.
`default_nettype none

package eucmbd_pkg;

	localparam int WORD_W             = 32;
	localparam int BYTE_W             = 8;
	localparam int LEN_W              = 3;
	localparam int NUM_SETS           = 4;
	localparam int REG_IDX_W          = 3;
	localparam int DEF_MAX_CHAR_BYTES = 4;

	localparam logic [BYTE_W-1:0] HIGH_BIT  = 8'h80;
	localparam logic [BYTE_W-1:0] SHIFT_SS2 = 8'h8e;
	localparam logic [BYTE_W-1:0] SHIFT_SS3 = 8'h8f;

	typedef enum logic [1:0] {
		SET_G0 = 2'd0,
		SET_G1 = 2'd1,
		SET_G2 = 2'd2,
		SET_G3 = 2'd3
	} code_set_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SET_LENGTHS = 3'd0,
		REG_SET0_TAG    = 3'd1,
		REG_SET1_TAG    = 3'd2,
		REG_SET2_TAG    = 3'd3,
		REG_SET3_TAG    = 3'd4,
		REG_CODE_MASK   = 3'd5,
		REG_INVALID     = 3'd6
	} reg_idx_t;

	localparam logic [NUM_SETS*LEN_W-1:0] RST_SET_LENGTHS = 12'h691;
	localparam logic [WORD_W-1:0] RST_SET0_TAG  = 32'h0000_0000;
	localparam logic [WORD_W-1:0] RST_SET1_TAG  = 32'h0000_8080;
	localparam logic [WORD_W-1:0] RST_SET2_TAG  = 32'h0000_0080;
	localparam logic [WORD_W-1:0] RST_SET3_TAG  = 32'h0000_8000;
	localparam logic [WORD_W-1:0] RST_CODE_MASK = 32'h0000_8080;
	localparam logic [WORD_W-1:0] RST_INVALID   = 32'h0000_fffd;

	typedef struct packed {
		logic [NUM_SETS*LEN_W-1:0]            set_lengths;
		logic [NUM_SETS-1:0][WORD_W-1:0]      set_tag;
		logic [WORD_W-1:0]                    code_mask;
		logic [WORD_W-1:0]                    invalid_value;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_input;
	} item_t;

	typedef struct packed {
		logic      mid_char;
		code_set_t cur_set;
	} core_st_t;

	function automatic code_set_t classify(input logic [BYTE_W-1:0] b);
		code_set_t set;
		if ((b & HIGH_BIT) == '0) begin
			set = SET_G0;
		end else if (b == SHIFT_SS3) begin
			set = SET_G3;
		end else if (b == SHIFT_SS2) begin
			set = SET_G2;
		end else begin
			set = SET_G1;
		end
		return set;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/eucmbd_if.sv
// Valid/ready channel interfaces of the EUC multibyte decoder:
// one for incoming stream bytes, one for decoded runes. No dependencies.
`default_nettype none

interface eucmbd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface eucmbd_rune_if;
	logic        valid;
	logic        ready;
	logic [31:0] rune_value;
	logic        status;

	modport source (output valid, output rune_value, output status, input ready);
	modport sink   (input valid, input rune_value, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/eucmbd_cfg.sv
// Configuration register file of the EUC multibyte decoder.
// Depends on eucmbd_pkg.
`default_nettype none

module eucmbd_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [eucmbd_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [eucmbd_pkg::WORD_W-1:0]       wr_data,
	output eucmbd_pkg::cfg_t                         cfg
);
	import eucmbd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_lengths       <= RST_SET_LENGTHS;
			cfg_q.set_tag[SET_G0]   <= RST_SET0_TAG;
			cfg_q.set_tag[SET_G1]   <= RST_SET1_TAG;
			cfg_q.set_tag[SET_G2]   <= RST_SET2_TAG;
			cfg_q.set_tag[SET_G3]   <= RST_SET3_TAG;
			cfg_q.code_mask         <= RST_CODE_MASK;
			cfg_q.invalid_value     <= RST_INVALID;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_SET_LENGTHS: cfg_q.set_lengths     <= wr_data[NUM_SETS*LEN_W-1:0];
				REG_SET0_TAG:    cfg_q.set_tag[SET_G0] <= wr_data;
				REG_SET1_TAG:    cfg_q.set_tag[SET_G1] <= wr_data;
				REG_SET2_TAG:    cfg_q.set_tag[SET_G2] <= wr_data;
				REG_SET3_TAG:    cfg_q.set_tag[SET_G3] <= wr_data;
				REG_CODE_MASK:   cfg_q.code_mask       <= wr_data;
				REG_INVALID:     cfg_q.invalid_value   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/eucmbd_in_stage.sv
// Input register of the EUC multibyte decoder: captures one stream word per
// cycle unless stalled, for the decode core. Depends on eucmbd_pkg, eucmbd_if.
`default_nettype none

module eucmbd_in_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	eucmbd_byte_if.sink      bytes,
	input  wire logic        take,
	output logic             valid_s1,
	output eucmbd_pkg::item_t item_s1
);
	import eucmbd_pkg::*;

	logic  v_s1;
	item_t d_s1;
	logic  accept;

	// The register may refill in the same cycle the core consumes it.
	assign bytes.ready = !v_s1 || take;
	assign accept      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (take) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1.data_byte    <= bytes.data_byte;
			d_s1.end_of_input <= bytes.end_of_input;
		end
	end

	assign valid_s1 = v_s1;
	assign item_s1  = d_s1;

endmodule

`default_nettype wire

>>> rtl/core/eucmbd_core.sv
// Decode core of the EUC multibyte decoder: character state, rune assembly
// and the result register. Depends on eucmbd_pkg, eucmbd_if.
`default_nettype none

module eucmbd_core #(
	parameter int MAX_CHAR_BYTES = eucmbd_pkg::DEF_MAX_CHAR_BYTES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire eucmbd_pkg::cfg_t  cfg,
	input  wire logic         valid_s1,
	input  wire eucmbd_pkg::item_t item_s1,
	output logic              take,
	eucmbd_rune_if.source     runes,
	output eucmbd_pkg::core_st_t st
);
	import eucmbd_pkg::*;

	localparam int ACC_W  = BYTE_W * MAX_CHAR_BYTES;
	localparam int LEFT_W = (MAX_CHAR_BYTES > 1) ? $clog2(MAX_CHAR_BYTES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHAR_BYTES);

	logic [LEFT_W-1:0] left_q;
	code_set_t         set_q;
	logic [ACC_W-1:0]  acc_q;
	logic              out_v_q;
	logic [WORD_W-1:0] rune_q;
	logic              status_q;

	code_set_t         cls;
	logic [LEN_W-1:0]  len_raw;
	logic [LEN_W-1:0]  len;
	logic [LEFT_W-1:0] nxt_left;
	code_set_t         nxt_set;
	logic [ACC_W-1:0]  nxt_acc;
	logic              done;
	logic              emit;
	logic [WORD_W-1:0] rune;

	always_comb begin
		cls     = classify(item_s1.data_byte);
		len_raw = cfg.set_lengths[int'(cls)*LEN_W +: LEN_W];
		if (len_raw == '0) begin
			len = LEN_W'(1);
		end else if (len_raw > MAX_LEN) begin
			len = MAX_LEN;
		end else begin
			len = len_raw;
		end

		if (left_q == '0) begin
			// First word of a character; shift words of sets 2 and 3 are not kept.
			nxt_set  = cls;
			nxt_left = LEFT_W'(len - LEN_W'(1));
			nxt_acc  = (cls == SET_G2 || cls == SET_G3) ? '0 : ACC_W'(item_s1.data_byte);
		end else begin
			nxt_set  = set_q;
			nxt_left = left_q - LEFT_W'(1);
			nxt_acc  = (acc_q << BYTE_W) | ACC_W'(item_s1.data_byte);
		end

		done = (nxt_left == '0);
		emit = done || item_s1.end_of_input;
		rune = (WORD_W'(nxt_acc) & ~cfg.code_mask) | cfg.set_tag[nxt_set];
	end

	assign take = valid_s1 && (!out_v_q || runes.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			set_q   <= SET_G0;
			acc_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				if (emit) begin
					left_q <= '0;
					set_q  <= SET_G0;
					acc_q  <= '0;
				end else begin
					left_q <= nxt_left;
					set_q  <= nxt_set;
					acc_q  <= nxt_acc;
				end
			end
			if (take && emit) begin
				out_v_q <= 1'b1;
			end else if (runes.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// A completed character wins over end of input on the same word.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			rune_q   <= done ? rune : cfg.invalid_value;
			status_q <= !done;
		end
	end

	assign runes.valid      = out_v_q;
	assign runes.rune_value = rune_q;
	assign runes.status     = status_q;

	assign st.mid_char = (left_q != '0);
	assign st.cur_set  = set_q;

endmodule

`default_nettype wire

>>> rtl/core/euc_multibyte_decoder.sv
// EUC multibyte decoder: takes one stream byte per cycle on the bytes channel and
// delivers one rune on the runes channel for every completed character, or the
// invalid value with status 1 when end of input cuts a character short. The block
// sustains one byte per clock unless the runes channel pushes back; each byte passes
// the input register, and its result is offered from the result register in the
// cycle after the core takes the byte. Back-pressure on the runes channel stalls
// both registers together. Registers are written through wr_en/wr_index/wr_data,
// by the user only while the block is idle; the block does not enforce this.
// Depends on eucmbd_pkg, eucmbd_if, eucmbd_cfg, eucmbd_in_stage, eucmbd_core.
`default_nettype none

`include "euc_multibyte_decoder_defines.svh"

module euc_multibyte_decoder #(
	parameter int MAX_CHAR_BYTES = eucmbd_pkg::DEF_MAX_CHAR_BYTES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	eucmbd_byte_if.sink                            bytes,
	eucmbd_rune_if.source                          runes,
	input  wire logic                              wr_en,
	input  wire logic [eucmbd_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [eucmbd_pkg::WORD_W-1:0]     wr_data
);
	import eucmbd_pkg::*;

	cfg_t     cfg;
	logic     valid_s1;
	item_t    item_s1;
	logic     take;
	core_st_t st;

	eucmbd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	eucmbd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	eucmbd_core #(
		.MAX_CHAR_BYTES (MAX_CHAR_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.runes    (runes),
		.st       (st)
	);

	// An empty input register must always be able to take a word.
	`EUCMBD_ASSERT_IMP(a_ready_when_empty, !valid_s1, bytes.ready, "input stalled while empty")
	// A new incomplete-status result can only come from a word marked end of input.
	`EUCMBD_ASSERT_IMP(a_incomplete_needs_end, $rose(runes.valid) && runes.status,
		$past(item_s1.end_of_input), "incomplete result without end of input")
	// Every emitted result leaves the core between characters.
	`EUCMBD_ASSERT_IMP(a_clear_after_result, $rose(runes.valid), !st.mid_char,
		"character state not cleared after a result")
	// Between characters the code set is back at set 0.
	`EUCMBD_ASSERT_IMP(a_idle_set_zero, !st.mid_char, st.cur_set == SET_G0,
		"stale code set between characters")

endmodule

`default_nettype wire

>>> tb/euc_multibyte_decoder_tb.sv
// Self-checking testbench for the EUC multibyte decoder: a directed table, then random phases.
// Each phase has its own register setting, and random idling runs on both channels.
// Depends on eucmbd_pkg, the eucmbd_byte_if/eucmbd_rune_if interfaces and the decoder RTL.
`default_nettype none

module euc_multibyte_decoder_tb;
	import eucmbd_pkg::*;

	localparam int unsigned MAX_LEN       = DEF_MAX_CHAR_BYTES;
	localparam int unsigned GAP_MAX       = 19;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned DRAIN_LIMIT   = 5000;
	localparam int unsigned HOLD_AT       = 150;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned N_PHASES      = 12;
	localparam int unsigned PHASE_BYTES   = 75;
	localparam int unsigned PRINT_CAP     = 40;

	localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam logic ST_COMPLETE = 1'b0;
	localparam logic ST_CUT      = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] rune;
		logic              status;
	} rune_t;

	typedef enum logic {ROW_BYTE, ROW_LENGTHS} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [11:0]       lengths;
		logic [7:0]        data_byte;
		logic              eoi;
		logic              use_row;
		logic [WORD_W-1:0] rune;
		logic              status;
	} row_t;

	localparam int N_DIRECTED = 27;
	localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ROW_BYTE,    12'h000, 8'h00, 1'b0, 1'b1, 32'h0000_0000, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h7f, 1'b0, 1'b1, 32'h0000_007f, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'ha1, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'hff, 1'b0, 1'b1, 32'h0000_a1ff, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h8e, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'hb5, 1'b0, 1'b1, 32'h0000_00b5, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h8f, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'ha1, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'ha2, 1'b0, 1'b1, 32'h0000_a122, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'hb0, 1'b1, 1'b1, 32'h0000_fffd, ST_CUT},
		'{ROW_BYTE,    12'h000, 8'h8f, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h80, 1'b1, 1'b1, 32'h0000_fffd, ST_CUT},
		'{ROW_BYTE,    12'h000, 8'hff, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'hff, 1'b0, 1'b1, 32'h0000_ffff, ST_COMPLETE},
		// All counts zero: every character is one byte, shift bytes stand alone.
		'{ROW_LENGTHS, 12'h000, 8'h00, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h8e, 1'b0, 1'b1, 32'h0000_0080, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h8f, 1'b0, 1'b1, 32'h0000_8000, ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'hc0, 1'b1, 1'b1, 32'h0000_80c0, ST_COMPLETE},
		// All counts seven: clamped to the four-byte maximum.
		'{ROW_LENGTHS, 12'hfff, 8'h00, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h8f, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h12, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h34, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h56, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'hf0, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h01, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h02, 1'b0, 1'b0, 32'h0,         ST_COMPLETE},
		'{ROW_BYTE,    12'h000, 8'h03, 1'b1, 1'b0, 32'h0,         ST_COMPLETE}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [WORD_W-1:0]    wr_data;

	eucmbd_byte_if bytes_if();
	eucmbd_rune_if runes_if();

	euc_multibyte_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes_if),
		.runes    (runes_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Register copy and character state of the decoder model.
	logic [11:0]       cfg_lengths;
	logic [WORD_W-1:0] cfg_tag [NUM_SETS];
	logic [WORD_W-1:0] cfg_mask;
	logic [WORD_W-1:0] cfg_invalid;
	logic [2:0]        dec_left;
	code_set_t         dec_set;
	logic [WORD_W-1:0] dec_acc;

	rune_t       expected_runes [$];
	int unsigned n_errors;
	int unsigned n_bytes;
	int unsigned n_runes;
	int unsigned n_cut;
	int unsigned n_settings;
	bit          send_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		if (n_errors < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		n_errors++;
	endtask

	function automatic code_set_t lead_set(input logic [7:0] b);
		if (!b[7]) return SET_G0;
		if (b == SHIFT_SS3) return SET_G3;
		if (b == SHIFT_SS2) return SET_G2;
		return SET_G1;
	endfunction

	function automatic int unsigned char_len(input code_set_t s);
		logic [2:0] n;
		n = cfg_lengths[int'(s)*3 +: 3];
		if (n == 3'd0) return 1;
		if (n > MAX_LEN) return MAX_LEN;
		return n;
	endfunction

	// Advances the character state by one byte; returns 1 when a rune is due.
	function automatic bit decode_byte(input logic [7:0] b, input logic eoi, output rune_t r);
		bit due;
		r   = '0;
		due = 1'b0;
		if (dec_left == 3'd0) begin
			dec_set  = lead_set(b);
			dec_acc  = (dec_set == SET_G2 || dec_set == SET_G3) ? '0 : {24'd0, b};
			dec_left = 3'(char_len(dec_set) - 1);
		end else begin
			dec_acc  = {dec_acc[23:0], b};
			dec_left = dec_left - 3'd1;
		end
		if (dec_left == 3'd0) begin
			r.rune   = (dec_acc & ~cfg_mask) | cfg_tag[dec_set];
			r.status = ST_COMPLETE;
			due      = 1'b1;
		end else if (eoi) begin
			r.rune   = cfg_invalid;
			r.status = ST_CUT;
			due      = 1'b1;
		end
		if (due) begin
			dec_left = 3'd0;
			dec_set  = SET_G0;
			dec_acc  = '0;
		end
		return due;
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			REG_SET_LENGTHS: cfg_lengths = val[11:0];
			REG_SET0_TAG:    cfg_tag[SET_G0] = val;
			REG_SET1_TAG:    cfg_tag[SET_G1] = val;
			REG_SET2_TAG:    cfg_tag[SET_G2] = val;
			REG_SET3_TAG:    cfg_tag[SET_G3] = val;
			REG_CODE_MASK:   cfg_mask = val;
			REG_INVALID:     cfg_invalid = val;
			default: ;
		endcase
	endtask

	// Offers one word after a random gap and holds it until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic eoi, input bit use_row,
			input rune_t row_res);
		int unsigned gap;
		rune_t       r;
		bit          due;
		gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
		repeat (gap) begin
			@(negedge clk);
			bytes_if.valid = 1'b0;
		end
		@(negedge clk);
		bytes_if.valid        = 1'b1;
		bytes_if.data_byte    = b;
		bytes_if.end_of_input = eoi;
		do @(posedge clk); while (!bytes_if.ready);
		due = decode_byte(b, eoi, r);
		if (use_row) begin
			expected_runes.push_back(row_res);
		end else if (due) begin
			expected_runes.push_back(r);
		end
		n_bytes++;
	endtask

	task automatic drain_block();
		int unsigned guard;
		@(negedge clk);
		bytes_if.valid = 1'b0;
		guard = 0;
		while (expected_runes.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Phase 0 clears every register, phase 1 sets every bit, later phases are random.
	task automatic configure_phase(input int unsigned k);
		logic [WORD_W-1:0] fill;
		fill = (k == 0) ? '0 : '1;
		for (int r = int'(REG_SET_LENGTHS); r <= int'(REG_INVALID); r++) begin
			write_reg(REG_IDX_W'(r), (k < 2) ? fill : WORD_W'($urandom()));
		end
		write_reg(REG_NONE, $urandom());
		n_settings++;
	endtask

	// Mostly whole characters of the current lengths with random content, some noise.
	task automatic random_phase(input int unsigned n);
		logic [7:0]  stream [$];
		logic [7:0]  b;
		code_set_t   s;
		int unsigned len;
		logic        eoi;
		while (stream.size() < n) begin
			if ($urandom_range(0, 9) == 0) begin
				stream.push_back(8'($urandom()));
			end else begin
				s = code_set_t'($urandom_range(0, NUM_SETS - 1));
				case (s)
					SET_G0: b = 8'($urandom_range(0, 127));
					SET_G2: b = SHIFT_SS2;
					SET_G3: b = SHIFT_SS3;
					default: begin
						do b = 8'($urandom_range(128, 255));
						while (b == SHIFT_SS2 || b == SHIFT_SS3);
					end
				endcase
				stream.push_back(b);
				len = char_len(s);
				for (int i = 1; i < int'(len); i++) begin
					stream.push_back(8'($urandom()));
				end
			end
		end
		for (int i = 0; i < stream.size(); i++) begin
			if ($urandom_range(0, 39) == 0) begin
				send_burst = !send_burst;
			end
			eoi = (i == stream.size() - 1) || ($urandom_range(0, 29) == 0);
			send_byte(stream[i], eoi, 1'b0, '0);
		end
	endtask

	// Rune side: random stalls, and one long hold-off that backs the block up.
	initial begin : rune_sink
		int unsigned stall;
		int unsigned taken;
		bit          recv_burst;
		runes_if.ready = 1'b0;
		taken          = 0;
		recv_burst     = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_AT) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					runes_if.ready = 1'b0;
				end
			end
			if ($urandom_range(0, 39) == 0) begin
				recv_burst = !recv_burst;
			end
			stall = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
			repeat (stall) begin
				@(negedge clk);
				runes_if.ready = 1'b0;
			end
			@(negedge clk);
			runes_if.ready = 1'b1;
			do @(posedge clk); while (!runes_if.valid);
			taken++;
		end
	end

	always @(posedge clk) begin : rune_check
		rune_t want;
		if (arst_n && runes_if.valid && runes_if.ready) begin
			if (expected_runes.size() == 0) begin
				flag_mismatch($sformatf("unexpected rune %08h status %0d",
					runes_if.rune_value, runes_if.status));
			end else begin
				want = expected_runes.pop_front();
				if (runes_if.rune_value !== want.rune) begin
					flag_mismatch($sformatf("rune %08h, expected %08h",
						runes_if.rune_value, want.rune));
				end
				if (runes_if.status !== want.status) begin
					flag_mismatch($sformatf("status %0d, expected %0d (rune %08h)",
						runes_if.status, want.status, want.rune));
				end
				n_runes++;
				if (want.status == ST_CUT) begin
					n_cut++;
				end
			end
		end
	end

	initial begin : stimulus
		row_t row;
		arst_n                = 1'b0;
		wr_en                 = 1'b0;
		wr_index              = REG_SET_LENGTHS;
		wr_data               = '0;
		bytes_if.valid        = 1'b0;
		bytes_if.data_byte    = '0;
		bytes_if.end_of_input = 1'b0;
		send_burst            = 1'b0;
		n_errors              = 0;
		n_bytes               = 0;
		n_runes               = 0;
		n_cut                 = 0;
		n_settings            = 1;
		cfg_lengths           = RST_SET_LENGTHS;
		cfg_tag[SET_G0]       = RST_SET0_TAG;
		cfg_tag[SET_G1]       = RST_SET1_TAG;
		cfg_tag[SET_G2]       = RST_SET2_TAG;
		cfg_tag[SET_G3]       = RST_SET3_TAG;
		cfg_mask              = RST_CODE_MASK;
		cfg_invalid           = RST_INVALID;
		dec_left              = 3'd0;
		dec_set               = SET_G0;
		dec_acc               = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_LENGTHS) begin
				drain_block();
				write_reg(REG_SET_LENGTHS, WORD_W'(row.lengths));
				n_settings++;
			end else begin
				send_byte(row.data_byte, row.eoi, row.use_row, rune_t'({row.rune, row.status}));
			end
		end
		drain_block();

		for (int unsigned k = 0; k < N_PHASES; k++) begin
			configure_phase(k);
			random_phase(PHASE_BYTES);
			drain_block();
		end

		if (expected_runes.size() != 0) begin
			flag_mismatch($sformatf("%0d runes never arrived", expected_runes.size()));
		end
		$display("Decoded %0d bytes into %0d runes, %0d of them cut short by end of input,",
			n_bytes, n_runes, n_cut);
		$display("under %0d register settings, all-zero and all-one among them.", n_settings);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/eucmbd_pkg.sv
rtl/core/eucmbd_if.sv
rtl/core/eucmbd_cfg.sv
rtl/core/eucmbd_in_stage.sv
rtl/core/eucmbd_core.sv
rtl/core/euc_multibyte_decoder.sv
tb/euc_multibyte_decoder_tb.sv
